[hdl/ids_pkg.sv]
// Shared types, CORDIC angle table and helpers for the direction sampler.
package ids_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_MIN_POLAR   = 2'd0,
        REG_MAX_POLAR   = 2'd1,
        REG_MIN_AZIMUTH = 2'd2,
        REG_MAX_AZIMUTH = 2'd3
    } cfg_reg_t;

    // cos/sin pair, Q1.16
    typedef struct packed {
        logic signed [17:0] cos_q;
        logic signed [17:0] sin_q;
    } trig_t;

    localparam int MAX_STAGES = 24;
    localparam logic signed [31:0] GAIN_INV = 32'sh26DD3B6A;
    localparam logic signed [39:0] Q16_ONE = 40'sd65536;

    // atan(2^-i) in 2^-32 turn
    localparam logic [31:0] STAGE_ANGLE [0:MAX_STAGES-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BF, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // saturate to [-1, 1] in Q16
    function automatic logic signed [17:0] clamp_q16(input logic signed [39:0] v);
        logic signed [17:0] r;
        if (v > Q16_ONE)
            r = 18'sd65536;
        else if (v < -Q16_ONE)
            r = -18'sd65536;
        else
            r = v[17:0];
        return r;
    endfunction

endpackage

[hdl/isotropic_direction_sampler_core.sv]
// Top level of the isotropic direction sampler: cone/wedge unit vector per beat.
//
//  channel | signals                                    | beat moves
//  --------+--------------------------------------------+---------------------------
//  in      | in_valid, in_ready, rand_polar, rand_azimuth | two uniform fractions
//  out     | out_valid, out_ready, dir_x, dir_y, dir_z  | one Q1.16 unit vector
//  cfg     | cfg_we, cfg_addr, cfg_wdata                | one register write
//
// One beat in and one beat out per cycle, sustained while the output is not stalled.
// The pipeline runs through the input register with the azimuth span product,
// three parallel CORDIC pipelines, the polar cosine interpolation and square,
// a 17-stage bit-per-stage square root plus rounding, the final multiply and
// the output register.
// rst_n clears the valid line and loads the register defaults.
// A stall at the output freezes the whole pipeline; in_ready follows it.
module isotropic_direction_sampler_core #(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    // input beats
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [15:0]         rand_polar,
    input  logic [15:0]         rand_azimuth,
    // result beats
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [17:0]  dir_x,
    output logic signed [17:0]  dir_y,
    output logic signed [17:0]  dir_z,
    // configuration writes
    input  logic                cfg_we,
    input  ids_pkg::cfg_reg_t   cfg_addr,
    input  logic [16:0]         cfg_wdata
);
    import ids_pkg::*;

    localparam int CL    = CORDIC_STAGES + 2;   // CORDIC latency
    localparam int VD    = CORDIC_STAGES + 26;  // total pipeline depth
    localparam int SQ    = 17;                  // square root stages
    localparam int TRIGD = SQ + 4;              // azimuth trig delay
    localparam int CTHD  = SQ + 3;              // polar cosine delay

    // ---------------- configuration registers ----------------
    logic [15:0] min_polar_reg, max_polar_reg;
    logic [16:0] min_az_reg, max_az_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_polar_reg <= 16'd0;
            max_polar_reg <= 16'd32768;
            min_az_reg    <= 17'd0;
            max_az_reg    <= 17'd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_MIN_POLAR:   min_polar_reg <= cfg_wdata[15:0];
                REG_MAX_POLAR:   max_polar_reg <= cfg_wdata[15:0];
                REG_MIN_AZIMUTH: min_az_reg    <= cfg_wdata;
                REG_MAX_AZIMUTH: max_az_reg    <= cfg_wdata;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic en;
    logic valid_reg [0:VD-1];

    assign en        = !valid_reg[VD-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = valid_reg[VD-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VD; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < VD; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    // ---------------- stage 1: azimuth span product ----------------
    logic signed [17:0] az_span;
    logic signed [34:0] az_prod;
    logic [15:0]        rp1_reg;
    logic [31:0]        azp1_reg;

    assign az_span = $signed({1'b0, max_az_reg}) - $signed({1'b0, min_az_reg});
    assign az_prod = $signed({1'b0, rand_azimuth}) * az_span;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rp1_reg  <= rand_polar;
            azp1_reg <= az_prod[31:0];
        end
    end

    // ---------------- CORDIC lanes ----------------
    logic [31:0] phi32;
    trig_t       tmin, tmax, tphi;

    // modulo one turn, in 2^-32 turn
    assign phi32 = {min_az_reg[15:0], 16'h0000} + azp1_reg;

    ids_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cord_min (
        .clk(clk), .en(en), .angle({min_polar_reg, 16'h0000}), .trig(tmin)
    );
    ids_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cord_max (
        .clk(clk), .en(en), .angle({max_polar_reg, 16'h0000}), .trig(tmax)
    );
    ids_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cord_phi (
        .clk(clk), .en(en), .angle(phi32), .trig(tphi)
    );

    // rand_polar rides alongside the CORDIC
    logic [15:0] rpd_reg [0:CL-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rpd_reg[0] <= rp1_reg;
            for (int i = 1; i < CL; i++)
                rpd_reg[i] <= rpd_reg[i-1];
        end
    end

    // ---------------- polar cosine interpolation ----------------
    logic signed [18:0] cdiff;
    logic signed [35:0] pmul;
    logic signed [35:0] pmul_reg;
    logic signed [17:0] cmin_reg;
    logic signed [36:0] pstep;
    logic signed [17:0] cth_reg;

    assign cdiff = 19'(tmin.cos_q) - 19'(tmax.cos_q);
    assign pmul  = $signed({1'b0, rpd_reg[CL-1]}) * cdiff;
    assign pstep = (37'(pmul_reg) + 37'sd32768) >>> 16;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pmul_reg <= pmul;
            cmin_reg <= tmin.cos_q;
            cth_reg  <= clamp_q16(40'(cmin_reg) - 40'(pstep));
        end
    end

    // radicand 1 - cos^2 in Q32
    logic signed [35:0] cth_sq;
    logic [32:0]        rad_reg;

    assign cth_sq = cth_reg * cth_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            rad_reg <= 33'h1_0000_0000 - cth_sq[32:0];
    end

    // ---------------- square root, one result bit per stage ----------------
    logic [33:0] n_reg [0:SQ-1];
    logic [33:0] r_reg [0:SQ-1];

    for (genvar j = 0; j < SQ; j++)
    begin : g_sqrt
        localparam logic [33:0] B = 34'd1 << (32 - 2 * j);
        logic [33:0] n_in, r_in, trial;

        if (j == 0)
        begin : g_first
            assign n_in = {1'b0, rad_reg};
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign n_in = n_reg[j-1];
            assign r_in = r_reg[j-1];
        end

        assign trial = r_in + B;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (n_in >= trial)
                begin
                    n_reg[j] <= n_in - trial;
                    r_reg[j] <= (r_in >> 1) + B;
                end
                else
                begin
                    n_reg[j] <= n_in;
                    r_reg[j] <= r_in >> 1;
                end
            end
        end
    end

    // round to nearest: remainder above root
    logic [16:0] sth_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            sth_reg <= r_reg[SQ-1][16:0] + 17'(n_reg[SQ-1] > r_reg[SQ-1]);
    end

    // ---------------- delay lines for azimuth trig and polar cosine ----------------
    trig_t              trig_reg [0:TRIGD-1];
    logic signed [17:0] cthd_reg [0:CTHD-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            trig_reg[0] <= tphi;
            for (int i = 1; i < TRIGD; i++)
                trig_reg[i] <= trig_reg[i-1];
            cthd_reg[0] <= cth_reg;
            for (int i = 1; i < CTHD; i++)
                cthd_reg[i] <= cthd_reg[i-1];
        end
    end

    // ---------------- final products and output register ----------------
    logic signed [35:0] px, py;
    logic signed [35:0] px_reg, py_reg;
    logic signed [36:0] xr, yr;
    logic signed [17:0] dirx_reg, diry_reg, dirz_reg;

    assign px = $signed({1'b0, sth_reg}) * trig_reg[TRIGD-1].cos_q;
    assign py = $signed({1'b0, sth_reg}) * trig_reg[TRIGD-1].sin_q;
    assign xr = (37'(px_reg) + 37'sd32768) >>> 16;
    assign yr = (37'(py_reg) + 37'sd32768) >>> 16;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg   <= px;
            py_reg   <= py;
            dirx_reg <= -xr[17:0];
            diry_reg <= -yr[17:0];
            dirz_reg <= -cthd_reg[CTHD-1];
        end
    end

    assign dir_x = dirx_reg;
    assign dir_y = diry_reg;
    assign dir_z = dirz_reg;

endmodule

[hdl/ids_cordic.sv]
// Pipelined rotation-mode CORDIC: angle in 2^-32 turn to cos/sin in Q1.16.
module ids_cordic #(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [31:0]          angle,
    output ids_pkg::trig_t       trig
);
    import ids_pkg::*;

    localparam int W  = ANGLE_BITS;
    localparam int ZW = ANGLE_BITS + 2;
    localparam logic [32:0] HALF   = 33'd1 << (31 - W);
    localparam logic [W:0]  EIGHTH = (W + 1)'(1) << (W - 3);

    logic signed [31:0]   x_reg [0:CORDIC_STAGES];
    logic signed [31:0]   y_reg [0:CORDIC_STAGES];
    logic signed [ZW-1:0] z_reg [0:CORDIC_STAGES];
    logic [1:0]           q_reg [0:CORDIC_STAGES];
    trig_t                trig_reg;

    // fold to [-1/8, 1/8) turn plus quadrant
    logic [32:0]          sum;
    logic [W-1:0]         p;
    logic [W:0]           pe;
    logic signed [ZW-1:0] z0;

    always_comb
    begin
        sum = {1'b0, angle} + HALF;
        p   = sum[31 -: W];
        pe  = {1'b0, p} + EIGHTH;
        z0  = $signed({4'b0, pe[W-3:0]}) - $signed(ZW'(EIGHTH));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= GAIN_INV;
            y_reg[0] <= '0;
            z_reg[0] <= z0;
            q_reg[0] <= pe[W-1:W-2];
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        localparam logic [32:0]   TS = {1'b0, STAGE_ANGLE[i]} + HALF;
        localparam logic [ZW-1:0] T  = ZW'(TS >> (32 - W));

        // x moves by shifted y, y by shifted x
        logic signed [31:0] dx, dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - $signed(T);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + $signed(T);
                end
                q_reg[i+1] <= q_reg[i];
            end
        end
    end

    // quadrant, round Q30 to Q16, saturate
    logic signed [31:0] c, s;
    logic signed [32:0] c_rnd, s_rnd;

    always_comb
    begin
        case (q_reg[CORDIC_STAGES])
            2'd0:    begin c =  x_reg[CORDIC_STAGES]; s =  y_reg[CORDIC_STAGES]; end
            2'd1:    begin c = -y_reg[CORDIC_STAGES]; s =  x_reg[CORDIC_STAGES]; end
            2'd2:    begin c = -x_reg[CORDIC_STAGES]; s = -y_reg[CORDIC_STAGES]; end
            default: begin c =  y_reg[CORDIC_STAGES]; s = -x_reg[CORDIC_STAGES]; end
        endcase
        c_rnd = (33'(c) + 33'sd8192) >>> 14;
        s_rnd = (33'(s) + 33'sd8192) >>> 14;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            trig_reg.cos_q <= clamp_q16(40'(c_rnd));
            trig_reg.sin_q <= clamp_q16(40'(s_rnd));
        end
    end

    assign trig = trig_reg;

endmodule

[tb/ids_checker.sv]
// Checker for the direction sampler: predicts each result beat and compares it.
`timescale 1ns / 1ps
module ids_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [15:0]        rand_polar,
    input  logic [15:0]        rand_azimuth,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [17:0] dir_x,
    input  logic signed [17:0] dir_y,
    input  logic signed [17:0] dir_z,
    input  logic               cfg_we,
    input  ids_pkg::cfg_reg_t  cfg_addr,
    input  logic [16:0]        cfg_wdata,
    output int                 fail_count,
    output int                 pending
);
    import ids_pkg::*;

    typedef struct {
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic signed [17:0] z;
    } dir_t;

    dir_t dir_q[$];
    logic [15:0] lim_pmin, lim_pmax;
    logic [16:0] lim_amin, lim_amax;

    localparam int ABITS  = 16;
    localparam int STAGES = 16;

    // angle table, own copy, 2^-32 turn
    localparam logic [31:0] ATAN_TURN [0:15] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    function automatic longint sat_unit(longint v);
        if (v > 65536) return 65536;
        if (v < -65536) return -65536;
        return v;
    endfunction

    // cos/sin in Q16 of an angle given in 2^-32 turn
    function automatic void trig_of(input longint unsigned a32,
                                    output longint cq, output longint sq);
        longint unsigned p, q, half;
        longint z, x, y, t, dx, dy, c, s;
        half = 64'd1 << (31 - ABITS);
        p = (((a32 & 64'hFFFFFFFF) + half) >> (32 - ABITS)) & 64'hFFFF;
        q = ((p + 64'h2000) >> (ABITS - 2)) & 3;
        z = longint'((p + 64'h2000 - q * 64'h4000) & 64'hFFFF) - 64'h2000;
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < STAGES; i++) begin
            t = longint'((64'(ATAN_TURN[i]) + half) >> (32 - ABITS));
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= t;
            end else begin
                x += dx; y -= dy; z += t;
            end
        end
        case (q)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        cq = sat_unit((c + 8192) >>> 14);
        sq = sat_unit((s + 8192) >>> 14);
    endfunction

    function automatic longint unsigned isqrt_nearest(longint unsigned v);
        longint unsigned r, b, n;
        r = 0;
        b = 64'd1 << 62;
        n = v;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else
                r >>= 1;
            b >>= 2;
        end
        if (v - r * r > r) r++;
        return r;
    endfunction

    function automatic dir_t sample_direction(logic [15:0] rp, logic [15:0] ra);
        longint cmin, cmax, cphi, sphi, junk, cth, sth, adiff;
        longint unsigned phi;
        dir_t d;
        trig_of(64'(lim_pmin) << 16, cmin, junk);
        trig_of(64'(lim_pmax) << 16, cmax, junk);
        cth = sat_unit(cmin - ((longint'(rp) * (cmin - cmax) + 32768) >>> 16));
        sth = longint'(isqrt_nearest(64'd4294967296 - longint'(cth * cth)));
        adiff = longint'(lim_amax) - longint'(lim_amin);
        phi = ((64'(lim_amin) << 16) + longint'(longint'(ra) * adiff)) & 64'hFFFFFFFF;
        trig_of(phi, cphi, sphi);
        d.x = 18'(-((sth * cphi + 32768) >>> 16));
        d.y = 18'(-((sth * sphi + 32768) >>> 16));
        d.z = 18'(-cth);
        return d;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge clk or negedge rst_n) begin
        dir_t w;
        if (!rst_n) begin
            lim_pmin = 16'd0;
            lim_pmax = 16'd32768;
            lim_amin = 17'd0;
            lim_amax = 17'd65536;
            dir_q.delete();
            pending = 0;
        end else begin
            if (in_valid && in_ready)
                dir_q.push_back(sample_direction(rand_polar, rand_azimuth));
            if (out_valid && out_ready) begin
                if (dir_q.size() == 0)
                    report("unexpected beat", dir_x, 0);
                else begin
                    w = dir_q.pop_front();
                    if (dir_x !== w.x) report("dir_x", dir_x, w.x);
                    if (dir_y !== w.y) report("dir_y", dir_y, w.y);
                    if (dir_z !== w.z) report("dir_z", dir_z, w.z);
                end
            end
            if (cfg_we) begin
                case (cfg_addr)
                    REG_MIN_POLAR:   lim_pmin = cfg_wdata[15:0];
                    REG_MAX_POLAR:   lim_pmax = cfg_wdata[15:0];
                    REG_MIN_AZIMUTH: lim_amin = cfg_wdata;
                    REG_MAX_AZIMUTH: lim_amax = cfg_wdata;
                    default: ;
                endcase
            end
            pending = dir_q.size();
        end
    end
endmodule

[tb/tb_isotropic_direction_sampler_core.sv]
// Testbench top for the direction sampler: stimulus, config phases and verdict.
`timescale 1ns / 1ps
module tb_isotropic_direction_sampler_core;
    import ids_pkg::*;

    logic clk, rst_n;
    logic in_valid, in_ready, out_valid, out_ready, cfg_we;
    logic [15:0] rand_polar, rand_azimuth;
    logic signed [17:0] dir_x, dir_y, dir_z;
    cfg_reg_t cfg_addr;
    logic [16:0] cfg_wdata;
    int fail_count, pending;
    int beats_sent;
    bit quiet;   // no idling in the closing stretch

    isotropic_direction_sampler_core dut (.*);
    ids_checker chk (.*);

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    // result side: random stall bursts unless in the closing stretch
    initial begin
        int n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 6);
                out_ready = 1'b0;
                repeat (n) @(negedge clk);
            end
            out_ready = 1'b1;
        end
    end

    // one beat: hold valid until accepted, maybe idle first
    task automatic send_beat(logic [15:0] rp, logic [15:0] ra);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid = 1'b1;
        rand_polar = rp;
        rand_azimuth = ra;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        beats_sent++;
    endtask

    // all results in, pipeline drained, then idle
    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t a, logic [16:0] v);
        cfg_we = 1'b1;
        cfg_addr = a;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_limits(logic [16:0] p0, logic [16:0] p1,
                              logic [16:0] a0, logic [16:0] a1);
        drain();
        write_reg(REG_MIN_POLAR, p0);
        write_reg(REG_MAX_POLAR, p1);
        write_reg(REG_MIN_AZIMUTH, a0);
        write_reg(REG_MAX_AZIMUTH, a1);
    endtask

    task automatic random_run(int n);
        repeat (n) send_beat(16'($urandom), 16'($urandom));
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        rand_polar = '0;
        rand_azimuth = '0;
        cfg_we = 1'b0;
        cfg_addr = REG_MIN_POLAR;
        cfg_wdata = '0;
        quiet = 0;
        beats_sent = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: field extremes and single bits, default full sphere
        send_beat(16'h0000, 16'h0000);
        send_beat(16'hFFFF, 16'hFFFF);
        send_beat(16'h8000, 16'h4000);
        send_beat(16'h0000, 16'hFFFF);
        send_beat(16'hFFFF, 16'h0000);
        send_beat(16'h5555, 16'hAAAA);
        send_beat(16'hAAAA, 16'h5555);
        send_beat(16'h0001, 16'h8000);
        send_beat(16'hC000, 16'hC000);
        // sender holds off until everything is back
        drain();
        // max polar below min, max azimuth below min: wraps the other way
        set_limits(17'd32768, 17'd0, 17'd65536, 17'd0);
        send_beat(16'h0000, 16'h0000);
        send_beat(16'hFFFF, 16'hFFFF);
        send_beat(16'h4000, 16'h2000);
        // beyond half turn polar, full-width azimuth registers, high bits ignored
        set_limits(17'h1FFFF, 17'h1C000, 17'h1FFFF, 17'h10000);
        send_beat(16'h0000, 16'h0000);
        send_beat(16'hFFFF, 16'hFFFF);
        send_beat(16'h7FFF, 16'h8001);
        // degenerate cone: fixed direction
        set_limits(17'd8192, 17'd8192, 17'd100, 17'd100);
        send_beat(16'hFFFF, 16'h1234);
        send_beat(16'h0000, 16'hEDCB);

        // random phases over several settings, extremes included
        set_limits(17'd0, 17'd32768, 17'd0, 17'd65536);
        random_run(120);
        set_limits(17'd0, 17'd0, 17'd0, 17'd0);
        random_run(40);
        set_limits(17'd32768, 17'd32768, 17'd65536, 17'd65536);
        random_run(40);
        repeat (4) begin
            set_limits(17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom));
            random_run(50);
        end
        set_limits(17'd0, 17'd4096, 17'd16384, 17'd32768);
        quiet = 1;
        random_run(80);

        drain();
        $display("%0d direction beats over default, reversed, out-of-range and random limits,",
                 beats_sent);
        $display("with random idle and stall bursts, then a back-to-back stretch");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

[files.f]
hdl/ids_pkg.sv
hdl/ids_cordic.sv
hdl/isotropic_direction_sampler_core.sv
tb/ids_checker.sv
tb/tb_isotropic_direction_sampler_core.sv
